FILE: rtl/core/btk_pkg.sv
package btk_pkg;

   localparam int ID_W    = 16;
   localparam int SCORE_W = 32;
   localparam int CAP_W   = 5;
   localparam int COUNT_W = 5;

   // command codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   // status codes
   localparam logic STATUS_DONE      = 1'b0;
   localparam logic STATUS_NOT_FOUND = 1'b1;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // one classified operation on its way from the front to the cell array
   typedef struct packed {
      logic                      is_remove;
      logic [ID_W-1:0]           entry_id;
      logic signed [SCORE_W-1:0] score;
   } btk_op_type;

endpackage

FILE: rtl/core/bounded_top_k_sorted_list.sv
// channel   direction  handshake              payload
// req_      in         req_valid / req_stall  command, entry_id, score
// rsp_      out        rsp_valid / rsp_stall  status, evicted_*, entry_count
// csr_      in         csr_wr_en              csr_wr_data (capacity)
//
// one transaction per cycle unless rsp stalls: every cell compares and shifts in parallel
// rsp_valid rises after req acceptance once the op has passed a queue slot, then the cell array
// reset clears the queue, the held count and the output valid; capacity returns to 16
// a stalled rsp holds the cell array; the 2-deep queue keeps taking req until full
// capacity writes take effect only while the list is empty
module bounded_top_k_sorted_list import btk_pkg::*; #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_command,
   input  logic [ID_W-1:0]           req_entry_id,
   input  logic signed [SCORE_W-1:0] req_score,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_status,
   output logic                      rsp_evicted_valid,
   output logic [ID_W-1:0]           rsp_evicted_id,
   output logic signed [SCORE_W-1:0] rsp_evicted_score,
   output logic [COUNT_W-1:0]        rsp_entry_count,
   // capacity register
   input  logic                      csr_wr_en,
   input  logic [CAP_W-1:0]          csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   // common width for comparing the 5-bit register against the entry limit
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   btk_op_type       op;
   logic             op_valid;
   logic             op_pop;
   logic [CNT_W-1:0] held_count;
   logic [CNT_W-1:0] eff_cap;

   logic [CAP_W-1:0] cap_ff, cap_in;

   // capacity register, writes ignored while entries are held
   always_comb begin
      cap_in = cap_ff;
      if (csr_wr_en && (held_count == '0)) begin
         cap_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // clamp the stored capacity into 1..MAX_ENTRIES
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(MAX_ENTRIES)) begin
         eff_cap = CNT_W'(MAX_ENTRIES);
      end else begin
         eff_cap = CNT_W'(cap_ff);
      end
   end

   // front: decode and queue
   btk_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_command  (req_command),
      .req_entry_id (req_entry_id),
      .req_score    (req_score),
      .op_valid     (op_valid),
      .op_pop       (op_pop),
      .op           (op)
   );

   // back: sorted cell array and response register
   btk_cells #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .CNT_W       (CNT_W)
   ) u_cells (
      .clock             (clock),
      .reset             (reset),
      .op_valid          (op_valid),
      .op_pop            (op_pop),
      .op                (op),
      .cap               (eff_cap),
      .held_count        (held_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_id    (rsp_evicted_id),
      .rsp_evicted_score (rsp_evicted_score),
      .rsp_entry_count   (rsp_entry_count)
   );

endmodule

FILE: rtl/core/btk_front.sv
module btk_front import btk_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_command,
   input  logic [ID_W-1:0]           req_entry_id,
   input  logic signed [SCORE_W-1:0] req_score,
   output logic                      op_valid,
   input  logic                      op_pop,
   output btk_op_type                op
);

   // two-entry queue between the port and the cell array
   btk_op_type q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   logic       do_pop;
   btk_op_type new_op;

   always_comb begin
      new_op.is_remove = (req_command == CMD_REMOVE);
      new_op.entry_id  = req_entry_id;
      new_op.score     = req_score;
   end

   assign req_stall = (fill_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign op_valid  = (fill_ff != 2'd0);
   assign do_pop    = op_pop && op_valid;
   assign op        = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (!push && do_pop) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_op;
      end
   end

endmodule

FILE: rtl/core/btk_cells.sv
module btk_cells import btk_pkg::*; #(
   parameter int MAX_ENTRIES = 16,
   parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      op_valid,
   output logic                      op_pop,
   input  btk_op_type                op,
   input  logic [CNT_W-1:0]          cap,
   output logic [CNT_W-1:0]          held_count,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_status,
   output logic                      rsp_evicted_valid,
   output logic [ID_W-1:0]           rsp_evicted_id,
   output logic signed [SCORE_W-1:0] rsp_evicted_score,
   output logic [COUNT_W-1:0]        rsp_entry_count
);

   logic [ID_W-1:0]           id_ff    [MAX_ENTRIES];
   logic signed [SCORE_W-1:0] score_ff [MAX_ENTRIES];
   logic [ID_W-1:0]           id_in    [MAX_ENTRIES];
   logic signed [SCORE_W-1:0] score_in [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0]    cell_we;

   logic [CNT_W-1:0] count_ff, count_in;

   logic [MAX_ENTRIES-1:0] occ, ge, hit, seen, is_last;
   logic                   found, full, new_lowest;
   logic [ID_W-1:0]           last_id;
   logic signed [SCORE_W-1:0] last_score;

   logic                      rsp_valid_ff;
   logic                      status_ff, status_in;
   logic                      ev_valid_ff, ev_valid_in;
   logic [ID_W-1:0]           ev_id_ff, ev_id_in;
   logic signed [SCORE_W-1:0] ev_score_ff, ev_score_in;
   logic [COUNT_W-1:0]        entry_count_ff, entry_count_in;

   assign op_pop     = op_valid && (!rsp_valid_ff || !rsp_stall);
   assign held_count = count_ff;

   // per-cell compare and shift decisions
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      localparam logic [MAX_ENTRIES-1:0] LOW_MASK = {MAX_ENTRIES{1'b1}} >> (MAX_ENTRIES - 1 - i);
      logic ins_here;

      assign occ[i]     = CNT_W'(i) < count_ff;
      assign ge[i]      = occ[i] && ($signed(score_ff[i]) >= $signed(op.score));
      assign hit[i]     = occ[i] && (id_ff[i] == op.entry_id) && (score_ff[i] == op.score);
      assign seen[i]    = |(hit & LOW_MASK);
      assign is_last[i] = CNT_W'(i + 1) == count_ff;

      if (i == 0) begin : g_first
         assign ins_here = !ge[i];
      end else begin : g_rest
         assign ins_here = !ge[i] && ge[i-1];
      end

      always_comb begin
         id_in[i]    = op.entry_id;
         score_in[i] = op.score;
         cell_we[i]  = 1'b0;
         if (!op.is_remove) begin
            // insert: everything from the insert point down moves one slot
            cell_we[i] = !ge[i];
            if (!ins_here) begin
               id_in[i]    = id_ff[(i > 0) ? i - 1 : 0];
               score_in[i] = score_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (i < MAX_ENTRIES - 1) begin
            // remove: everything from the first match down moves up one slot
            cell_we[i]  = seen[i];
            id_in[i]    = id_ff[(i < MAX_ENTRIES - 1) ? i + 1 : i];
            score_in[i] = score_ff[(i < MAX_ENTRIES - 1) ? i + 1 : i];
         end
      end

      always_ff @(posedge clock) begin
         if (op_pop && cell_we[i]) begin
            id_ff[i]    <= id_in[i];
            score_ff[i] <= score_in[i];
         end
      end
   end

   // tail entry select, one-hot on the last occupied cell
   always_comb begin
      last_id    = '0;
      last_score = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         last_id    = last_id | (is_last[i] ? id_ff[i] : '0);
         last_score = last_score | (is_last[i] ? score_ff[i] : '0);
      end
   end

   assign found      = |hit;
   assign full       = count_ff >= cap;
   assign new_lowest = |(ge & is_last);

   always_comb begin
      count_in    = count_ff;
      status_in   = STATUS_DONE;
      ev_valid_in = 1'b0;
      ev_id_in    = '0;
      ev_score_in = '0;
      if (!op.is_remove) begin
         if (full) begin
            ev_valid_in = 1'b1;
            ev_id_in    = new_lowest ? op.entry_id : last_id;
            ev_score_in = new_lowest ? op.score : last_score;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else if (found) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         status_in = STATUS_NOT_FOUND;
      end
      entry_count_in = COUNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (op_pop) begin
            count_ff <= count_in;
         end
         if (op_pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (op_pop) begin
         status_ff      <= status_in;
         ev_valid_ff    <= ev_valid_in;
         ev_id_ff       <= ev_id_in;
         ev_score_ff    <= ev_score_in;
         entry_count_ff <= entry_count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_evicted_valid = ev_valid_ff;
   assign rsp_evicted_id    = ev_id_ff;
   assign rsp_evicted_score = ev_score_ff;
   assign rsp_entry_count   = entry_count_ff;

   a_count_within_cap : assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap)
      else $error("held count above capacity");

   a_insert_grows_or_evicts : assert property (@(posedge clock) disable iff (reset)
      op_pop && !op.is_remove |=>
         (count_ff == CNT_W'($past(count_ff) + CNT_W'(1))) || rsp_evicted_valid)
      else $error("insert neither grew the list nor evicted");

   a_miss_keeps_count : assert property (@(posedge clock) disable iff (reset)
      op_pop && op.is_remove && !found |=> count_ff == $past(count_ff))
      else $error("failed remove changed the count");

endmodule
